### rtl/core/assert_macros.svh
// Assertion macros shared by the friction motion step block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property with a synchronous active-low reset disable
`define PFMS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pfms assertion failed");
// Implication form: antecedent, then consequent in the following cycle
`define PFMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfms assertion failed");
`else
`define PFMS_ASSERT(lbl, clk, rst_n, prop)
`define PFMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/pfms_pkg.sv
// Shared types, constants and helper functions for the friction motion step block
package pfms_pkg;

  localparam int DATA_W  = 32;
  localparam int DT_W    = 16;
  localparam int MASS_W  = 27;
  localparam int FRIC_W  = 21;
  localparam int GRAV_W  = 27;
  localparam int DVD_W   = 64;
  localparam int DVS_W   = 32;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int MAG_W   = 48;
  localparam int ADDR_W  = 4;

  localparam logic [MASS_W-1:0] MASS_RST = MASS_W'(65536);
  localparam logic [GRAV_W-1:0] GRAV_RST = GRAV_W'(642253);

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_ENABLED  = 2'd0;
  localparam logic [1:0] REG_MASS     = 2'd1;
  localparam logic [1:0] REG_FRICTION = 2'd2;
  localparam logic [1:0] REG_GRAVITY  = 2'd3;

  typedef enum logic [1:0] {
    OP_FORCE = 2'd0,
    OP_STEP  = 2'd1,
    OP_LOAD  = 2'd2
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE,
    S_F_MUL, S_F_DIV, S_F_WAIT, S_F_ADD,
    S_SQ_X, S_SQ_Y, S_SQRT_GO, S_GF, S_GFD, S_SQRT_WAIT,
    S_R_MUL, S_R_DIV, S_R_WAIT, S_R_APPLY,
    S_P_MUL, S_P_ADD,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LATCH, DP_LOAD,
    DP_FMUL, DP_DIV_MASS, DP_FADD,
    DP_SQX, DP_SQY, DP_SQRT_GO, DP_GF, DP_GFD,
    DP_RMUL, DP_DIV_LEN, DP_RAPPLY,
    DP_PMUL, DP_PADD,
    DP_CAPTURE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   axis;   // 0 selects x, 1 selects y
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       vel_nz;
    logic       div_busy;
    logic       sqrt_busy;
  } dp_stat_t;

  localparam logic signed [49:0] SAT_HI = 50'sh0_7FFF_FFFF;
  localparam logic signed [49:0] SAT_LO = -50'sh0_8000_0000;

  // Magnitude of a signed word; the most negative value maps to 2^31
  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] n;
    n = -v;
    return v[DATA_W-1] ? $unsigned(n) : $unsigned(v);
  endfunction

  // Add a signed magnitude to a word and saturate to 32 bits
  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] base,
    input logic                     neg,
    input logic [MAG_W-1:0]         mag
  );
    logic signed [49:0] b;
    logic signed [49:0] s;
    logic signed [49:0] sum;
    b = 50'(base);
    s = $signed({2'b00, mag});
    if (neg) begin
      s = -s;
    end
    sum = b + s;
    if (sum > SAT_HI) begin
      return 32'sh7FFF_FFFF;
    end else if (sum < SAT_LO) begin
      return 32'sh8000_0000;
    end
    return $signed(sum[DATA_W-1:0]);
  endfunction

endpackage

### rtl/core/pfms_div.sv
// Restoring divider, one quotient bit per cycle
module pfms_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pfms_pkg::DVD_W-1:0]    dividend,
  input  logic [pfms_pkg::DVS_W-1:0]    divisor,
  output logic                          busy,
  output logic [pfms_pkg::DVD_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(pfms_pkg::DVD_W);

  logic                         busy_r, busy_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [pfms_pkg::DVD_W-1:0]   quo_r, quo_nxt;
  logic [pfms_pkg::DVS_W-1:0]   rem_r, rem_nxt;
  logic [pfms_pkg::DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [pfms_pkg::DVS_W:0]     sh;
  logic                         ge;

  // Shift in one dividend bit and try the subtraction
  always_comb begin
    sh       = {rem_r, quo_r[pfms_pkg::DVD_W-1]};
    ge       = (sh >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? pfms_pkg::DVS_W'(sh - {1'b0, dvs_r}) : sh[pfms_pkg::DVS_W-1:0];
      quo_nxt = {quo_r[pfms_pkg::DVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(pfms_pkg::DVD_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

### rtl/core/pfms_sqrt.sv
// Integer square root, one root bit per cycle
module pfms_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pfms_pkg::RAD_W-1:0]    radicand,
  output logic                          busy,
  output logic [pfms_pkg::ROOT_W-1:0]   root
);

  localparam int CNT_W = $clog2(pfms_pkg::ROOT_W);
  localparam int REM_W = pfms_pkg::ROOT_W + 3;

  logic                          busy_r, busy_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [pfms_pkg::RAD_W-1:0]    x_r, x_nxt;
  logic [REM_W-1:0]              rem_r, rem_nxt;
  logic [pfms_pkg::ROOT_W-1:0]   root_r, root_nxt;
  logic [REM_W-1:0]              sh;
  logic [REM_W-1:0]              trial;
  logic                          ge;

  // Bring down two radicand bits and compare against 4*root+1
  always_comb begin
    sh       = {rem_r[REM_W-3:0], x_r[pfms_pkg::RAD_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    ge       = (sh >= trial);
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? (sh - trial) : sh;
      root_nxt = {root_r[pfms_pkg::ROOT_W-2:0], ge};
      x_nxt    = {x_r[pfms_pkg::RAD_W-3:0], 2'b00};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(pfms_pkg::ROOT_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

### rtl/core/pfms_dp.sv
// Datapath: body state, input latch, shared multiplier, divider and square root
module pfms_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pfms_pkg::dp_cmd_t                   cmd,
  output pfms_pkg::dp_stat_t                  stat,
  input  logic [1:0]                          in_operation,
  input  logic [pfms_pkg::DT_W-1:0]           in_dt,
  input  logic signed [pfms_pkg::DATA_W-1:0]  in_force_x,
  input  logic signed [pfms_pkg::DATA_W-1:0]  in_force_y,
  input  logic signed [pfms_pkg::DATA_W-1:0]  in_load_pos_x,
  input  logic signed [pfms_pkg::DATA_W-1:0]  in_load_pos_y,
  input  logic signed [pfms_pkg::DATA_W-1:0]  in_load_vel_x,
  input  logic signed [pfms_pkg::DATA_W-1:0]  in_load_vel_y,
  input  logic [pfms_pkg::MASS_W-1:0]         body_mass,
  input  logic [pfms_pkg::FRIC_W-1:0]         friction_coef,
  input  logic [pfms_pkg::GRAV_W-1:0]         gravity_accel,
  output logic signed [pfms_pkg::DATA_W-1:0]  out_pos_x,
  output logic signed [pfms_pkg::DATA_W-1:0]  out_pos_y,
  output logic signed [pfms_pkg::DATA_W-1:0]  out_vel_x,
  output logic signed [pfms_pkg::DATA_W-1:0]  out_vel_y
);

  localparam int W = pfms_pkg::DATA_W;
  localparam int DT_W_SHIFT = pfms_pkg::DT_W;

  // Latched transaction
  logic [1:0]                 op_r, op_nxt;
  logic [pfms_pkg::DT_W-1:0]  dt_r, dt_nxt;
  logic signed [W-1:0]        fx_r, fx_nxt, fy_r, fy_nxt;
  logic signed [W-1:0]        lpx_r, lpx_nxt, lpy_r, lpy_nxt;
  logic signed [W-1:0]        lvx_r, lvx_nxt, lvy_r, lvy_nxt;

  // Body state and result copy
  logic signed [W-1:0]        px_r, px_nxt, py_r, py_nxt;
  logic signed [W-1:0]        vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [W-1:0]        opx_r, opx_nxt, opy_r, opy_nxt;
  logic signed [W-1:0]        ovx_r, ovx_nxt, ovy_r, ovy_nxt;

  // Scratch
  logic [2*W-1:0]             prod_r, prod_nxt;
  logic [2*W-1:0]             acc_r, acc_nxt;
  logic [W-1:0]               dec_r, dec_nxt;

  logic [W-1:0]               mul_a, mul_b;
  logic [2*W-1:0]             mul_p;
  logic [2*W-1:0]             gfd_p;
  logic signed [W-1:0]        v_sel, p_sel, f_sel, v_new, p_new;
  logic [W-1:0]               m_sel, diff;
  logic [W-1:0]               mass_eff;

  logic                           div_start, div_busy;
  logic [pfms_pkg::DVS_W-1:0]     div_dvs;
  logic [pfms_pkg::DVD_W-1:0]     quo;
  logic                           sqrt_start, sqrt_busy;
  logic [pfms_pkg::RAD_W-1:0]     rad;
  logic [pfms_pkg::ROOT_W-1:0]    len;

  // Axis selection
  assign v_sel    = cmd.axis ? vy_r : vx_r;
  assign p_sel    = cmd.axis ? py_r : px_r;
  assign f_sel    = cmd.axis ? fy_r : fx_r;
  assign m_sel    = pfms_pkg::mag32(v_sel);
  assign diff     = m_sel - quo[W-1:0];
  assign mass_eff = (body_mass == '0) ? W'(1) : W'(body_mass);

  // Shared multiplier and the dt scaling of gravity*friction
  assign mul_p = mul_a * mul_b;
  assign gfd_p = prod_r[pfms_pkg::MAG_W-1:0] * dt_r;

  assign div_start  = (cmd.op == pfms_pkg::DP_DIV_MASS) || (cmd.op == pfms_pkg::DP_DIV_LEN);
  assign div_dvs    = (cmd.op == pfms_pkg::DP_DIV_LEN) ? len : mass_eff;
  assign sqrt_start = (cmd.op == pfms_pkg::DP_SQRT_GO);
  assign rad        = acc_r + prod_r;

  pfms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (quo)
  );

  pfms_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (rad),
    .busy     (sqrt_busy),
    .root     (len)
  );

  // Multiplier operands per command
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      pfms_pkg::DP_FMUL: begin
        mul_a = pfms_pkg::mag32(f_sel);
        mul_b = W'(dt_r);
      end
      pfms_pkg::DP_SQX: begin
        mul_a = pfms_pkg::mag32(vx_r);
        mul_b = pfms_pkg::mag32(vx_r);
      end
      pfms_pkg::DP_SQY: begin
        mul_a = pfms_pkg::mag32(vy_r);
        mul_b = pfms_pkg::mag32(vy_r);
      end
      pfms_pkg::DP_GF: begin
        mul_a = W'(gravity_accel);
        mul_b = W'(friction_coef);
      end
      pfms_pkg::DP_RMUL: begin
        mul_a = dec_r;
        mul_b = m_sel;
      end
      pfms_pkg::DP_PMUL: begin
        mul_a = m_sel;
        mul_b = W'(dt_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Velocity and position updates for the selected axis
  always_comb begin
    if (quo >= {{(pfms_pkg::DVD_W-W){1'b0}}, m_sel}) begin
      v_new = '0;
    end else begin
      v_new = v_sel[W-1] ? $signed(~diff + 1'b1) : $signed(diff);
    end
    p_new = pfms_pkg::sat_add(p_sel, v_sel[W-1], prod_r[2*W-1:DT_W_SHIFT]);
  end

  // Next-state logic for all datapath registers
  always_comb begin
    op_nxt   = op_r;   dt_nxt  = dt_r;
    fx_nxt   = fx_r;   fy_nxt  = fy_r;
    lpx_nxt  = lpx_r;  lpy_nxt = lpy_r;
    lvx_nxt  = lvx_r;  lvy_nxt = lvy_r;
    px_nxt   = px_r;   py_nxt  = py_r;
    vx_nxt   = vx_r;   vy_nxt  = vy_r;
    opx_nxt  = opx_r;  opy_nxt = opy_r;
    ovx_nxt  = ovx_r;  ovy_nxt = ovy_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    dec_nxt  = dec_r;
    unique case (cmd.op)
      pfms_pkg::DP_LATCH: begin
        op_nxt  = in_operation;
        dt_nxt  = in_dt;
        fx_nxt  = in_force_x;
        fy_nxt  = in_force_y;
        lpx_nxt = in_load_pos_x;
        lpy_nxt = in_load_pos_y;
        lvx_nxt = in_load_vel_x;
        lvy_nxt = in_load_vel_y;
      end
      pfms_pkg::DP_LOAD: begin
        px_nxt = lpx_r;
        py_nxt = lpy_r;
        vx_nxt = lvx_r;
        vy_nxt = lvy_r;
      end
      pfms_pkg::DP_FMUL, pfms_pkg::DP_SQX, pfms_pkg::DP_GF,
      pfms_pkg::DP_RMUL, pfms_pkg::DP_PMUL: begin
        prod_nxt = mul_p;
      end
      pfms_pkg::DP_SQY: begin
        acc_nxt  = prod_r;
        prod_nxt = mul_p;
      end
      pfms_pkg::DP_GFD: begin
        dec_nxt = gfd_p[2*W-1:W];
      end
      pfms_pkg::DP_FADD: begin
        if (cmd.axis) begin
          vy_nxt = pfms_pkg::sat_add(vy_r, f_sel[W-1], quo[pfms_pkg::MAG_W-1:0]);
        end else begin
          vx_nxt = pfms_pkg::sat_add(vx_r, f_sel[W-1], quo[pfms_pkg::MAG_W-1:0]);
        end
      end
      pfms_pkg::DP_RAPPLY: begin
        if (cmd.axis) begin
          vy_nxt = v_new;
        end else begin
          vx_nxt = v_new;
        end
      end
      pfms_pkg::DP_PADD: begin
        if (cmd.axis) begin
          py_nxt = p_new;
        end else begin
          px_nxt = p_new;
        end
      end
      pfms_pkg::DP_CAPTURE: begin
        opx_nxt = px_r;
        opy_nxt = py_r;
        ovx_nxt = vx_r;
        ovy_nxt = vy_r;
      end
      default: begin
        prod_nxt = prod_r;
      end
    endcase
  end

  // Body state resets to rest at the origin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
      vx_r <= '0;
      vy_r <= '0;
    end else begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;   dt_r  <= dt_nxt;
    fx_r   <= fx_nxt;   fy_r  <= fy_nxt;
    lpx_r  <= lpx_nxt;  lpy_r <= lpy_nxt;
    lvx_r  <= lvx_nxt;  lvy_r <= lvy_nxt;
    opx_r  <= opx_nxt;  opy_r <= opy_nxt;
    ovx_r  <= ovx_nxt;  ovy_r <= ovy_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    dec_r  <= dec_nxt;
  end

  assign stat.op        = op_r;
  assign stat.vel_nz    = (vx_r != '0) || (vy_r != '0);
  assign stat.div_busy  = div_busy;
  assign stat.sqrt_busy = sqrt_busy;

  assign out_pos_x = opx_r;
  assign out_pos_y = opy_r;
  assign out_vel_x = ovx_r;
  assign out_vel_y = ovy_r;

endmodule

### rtl/core/pfms_ctrl.sv
// Controller: sequences the datapath for each transaction and owns the handshakes
module pfms_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 enabled,
  input  pfms_pkg::dp_stat_t   stat,
  output pfms_pkg::dp_cmd_t    cmd
);

  pfms_pkg::ctrl_state_t state_r, state_nxt;
  logic                  axis_r, axis_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfms_pkg::S_IDLE;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state, commands and handshake outputs
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = pfms_pkg::DP_NOP;
    cmd.axis      = axis_r;
    in_ready      = 1'b0;
    unique case (state_r)
      pfms_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = pfms_pkg::DP_LATCH;
          state_nxt = pfms_pkg::S_DECODE;
        end
      end
      pfms_pkg::S_DECODE: begin
        axis_nxt = 1'b0;
        unique case (stat.op)
          pfms_pkg::OP_FORCE: state_nxt = pfms_pkg::S_F_MUL;
          pfms_pkg::OP_STEP: begin
            if (!enabled) begin
              state_nxt = pfms_pkg::S_FINISH;
            end else if (stat.vel_nz) begin
              state_nxt = pfms_pkg::S_SQ_X;
            end else begin
              state_nxt = pfms_pkg::S_P_MUL;
            end
          end
          pfms_pkg::OP_LOAD: begin
            cmd.op    = pfms_pkg::DP_LOAD;
            state_nxt = pfms_pkg::S_FINISH;
          end
          default: state_nxt = pfms_pkg::S_FINISH;
        endcase
      end
      // Force: |F|*dt / mass per axis
      pfms_pkg::S_F_MUL: begin
        cmd.op    = pfms_pkg::DP_FMUL;
        state_nxt = pfms_pkg::S_F_DIV;
      end
      pfms_pkg::S_F_DIV: begin
        cmd.op    = pfms_pkg::DP_DIV_MASS;
        state_nxt = pfms_pkg::S_F_WAIT;
      end
      pfms_pkg::S_F_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = pfms_pkg::S_F_ADD;
        end
      end
      pfms_pkg::S_F_ADD: begin
        cmd.op = pfms_pkg::DP_FADD;
        if (axis_r) begin
          state_nxt = pfms_pkg::S_FINISH;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = pfms_pkg::S_F_MUL;
        end
      end
      // Friction: speed and decrement, the decrement overlapping the root
      pfms_pkg::S_SQ_X: begin
        cmd.op    = pfms_pkg::DP_SQX;
        state_nxt = pfms_pkg::S_SQ_Y;
      end
      pfms_pkg::S_SQ_Y: begin
        cmd.op    = pfms_pkg::DP_SQY;
        state_nxt = pfms_pkg::S_SQRT_GO;
      end
      pfms_pkg::S_SQRT_GO: begin
        cmd.op    = pfms_pkg::DP_SQRT_GO;
        state_nxt = pfms_pkg::S_GF;
      end
      pfms_pkg::S_GF: begin
        cmd.op    = pfms_pkg::DP_GF;
        state_nxt = pfms_pkg::S_GFD;
      end
      pfms_pkg::S_GFD: begin
        cmd.op    = pfms_pkg::DP_GFD;
        state_nxt = pfms_pkg::S_SQRT_WAIT;
      end
      pfms_pkg::S_SQRT_WAIT: begin
        if (!stat.sqrt_busy) begin
          axis_nxt  = 1'b0;
          state_nxt = pfms_pkg::S_R_MUL;
        end
      end
      pfms_pkg::S_R_MUL: begin
        cmd.op    = pfms_pkg::DP_RMUL;
        state_nxt = pfms_pkg::S_R_DIV;
      end
      pfms_pkg::S_R_DIV: begin
        cmd.op    = pfms_pkg::DP_DIV_LEN;
        state_nxt = pfms_pkg::S_R_WAIT;
      end
      pfms_pkg::S_R_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = pfms_pkg::S_R_APPLY;
        end
      end
      pfms_pkg::S_R_APPLY: begin
        cmd.op = pfms_pkg::DP_RAPPLY;
        if (axis_r) begin
          axis_nxt  = 1'b0;
          state_nxt = pfms_pkg::S_P_MUL;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = pfms_pkg::S_R_MUL;
        end
      end
      // Position: |v|*dt >> 16 per axis
      pfms_pkg::S_P_MUL: begin
        cmd.op    = pfms_pkg::DP_PMUL;
        state_nxt = pfms_pkg::S_P_ADD;
      end
      pfms_pkg::S_P_ADD: begin
        cmd.op = pfms_pkg::DP_PADD;
        if (axis_r) begin
          state_nxt = pfms_pkg::S_FINISH;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = pfms_pkg::S_P_MUL;
        end
      end
      // Hold until the output register is free, then publish
      pfms_pkg::S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = pfms_pkg::DP_CAPTURE;
          out_valid_nxt = 1'b1;
          state_nxt     = pfms_pkg::S_IDLE;
        end
      end
      default: state_nxt = pfms_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/core/planar_friction_motion_step.sv
// Planar body motion step with Coulomb friction: top level, registers, assertions
// One transaction at a time, bounded by the bit-serial divider (twice for a force or
// a moving time step) and the bit-serial root (once for a moving time step).
// A new transaction is taken while a result waits in the output register.
// Synchronous active-low reset: body at rest at the origin, registers at defaults.
`include "assert_macros.svh"
module planar_friction_motion_step (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_operation,
  input  logic [pfms_pkg::DT_W-1:0]           in_dt,
  input  logic signed [pfms_pkg::DATA_W-1:0]  in_force_x,
  input  logic signed [pfms_pkg::DATA_W-1:0]  in_force_y,
  input  logic signed [pfms_pkg::DATA_W-1:0]  in_load_pos_x,
  input  logic signed [pfms_pkg::DATA_W-1:0]  in_load_pos_y,
  input  logic signed [pfms_pkg::DATA_W-1:0]  in_load_vel_x,
  input  logic signed [pfms_pkg::DATA_W-1:0]  in_load_vel_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pfms_pkg::DATA_W-1:0]  out_pos_x,
  output logic signed [pfms_pkg::DATA_W-1:0]  out_pos_y,
  output logic signed [pfms_pkg::DATA_W-1:0]  out_vel_x,
  output logic signed [pfms_pkg::DATA_W-1:0]  out_vel_y,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pfms_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic                          enabled_r, enabled_nxt;
  logic [pfms_pkg::MASS_W-1:0]   mass_r, mass_nxt;
  logic [pfms_pkg::FRIC_W-1:0]   fric_r, fric_nxt;
  logic [pfms_pkg::GRAV_W-1:0]   grav_r, grav_nxt;
  logic                          wr_en;
  logic [1:0]                    reg_idx;

  pfms_pkg::dp_cmd_t  cmd;
  pfms_pkg::dp_stat_t stat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register write decode
  always_comb begin
    enabled_nxt = enabled_r;
    mass_nxt    = mass_r;
    fric_nxt    = fric_r;
    grav_nxt    = grav_r;
    if (wr_en) begin
      unique case (reg_idx)
        pfms_pkg::REG_ENABLED:  enabled_nxt = pwdata[0];
        pfms_pkg::REG_MASS:     mass_nxt    = pwdata[pfms_pkg::MASS_W-1:0];
        pfms_pkg::REG_FRICTION: fric_nxt    = pwdata[pfms_pkg::FRIC_W-1:0];
        pfms_pkg::REG_GRAVITY:  grav_nxt    = pwdata[pfms_pkg::GRAV_W-1:0];
        default:                enabled_nxt = enabled_r;
      endcase
    end
  end

  // Register read mux
  always_comb begin
    unique case (reg_idx)
      pfms_pkg::REG_ENABLED:  prdata = 32'(enabled_r);
      pfms_pkg::REG_MASS:     prdata = 32'(mass_r);
      pfms_pkg::REG_FRICTION: prdata = 32'(fric_r);
      pfms_pkg::REG_GRAVITY:  prdata = 32'(grav_r);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      mass_r    <= pfms_pkg::MASS_RST;
      fric_r    <= '0;
      grav_r    <= pfms_pkg::GRAV_RST;
    end else begin
      enabled_r <= enabled_nxt;
      mass_r    <= mass_nxt;
      fric_r    <= fric_nxt;
      grav_r    <= grav_nxt;
    end
  end

  pfms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .enabled   (enabled_r),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfms_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_operation  (in_operation),
    .in_dt         (in_dt),
    .in_force_x    (in_force_x),
    .in_force_y    (in_force_y),
    .in_load_pos_x (in_load_pos_x),
    .in_load_pos_y (in_load_pos_y),
    .in_load_vel_x (in_load_vel_x),
    .in_load_vel_y (in_load_vel_y),
    .body_mass     (mass_r),
    .friction_coef (fric_r),
    .gravity_accel (grav_r),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_vel_x     (out_vel_x),
    .out_vel_y     (out_vel_y)
  );

  // An accepted transaction keeps the block busy for at least the next cycle
  `PFMS_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  // A fresh result only appears when the sequencer has been working
  `PFMS_ASSERT(a_result_after_work, clk, rst_n, $rose(out_valid) |-> !$past(in_ready))
  // The controller idles only while no divide is running
  `PFMS_ASSERT(a_idle_div_quiet, clk, rst_n, in_ready |-> !stat.div_busy)

endmodule
